@@ rtl/lep_pkg.sv @@
// ============================================================================
// lep_pkg
// Shared types, symbol codes and grammar tables of the LL(1) expression parser.
// ============================================================================
package lep_pkg;

   // Stack geometry
   localparam int STACK_DEPTH = 128;
   localparam int SP_WIDTH    = $clog2(STACK_DEPTH);
   localparam int POS_WIDTH   = 16;

   // Grammar symbols: terminals then nonterminals
   localparam logic [3:0] SYM_NONE = 4'd0;
   localparam logic [3:0] SYM_ADD  = 4'd1;
   localparam logic [3:0] SYM_SUB  = 4'd2;
   localparam logic [3:0] SYM_MUL  = 4'd3;
   localparam logic [3:0] SYM_DIV  = 4'd4;
   localparam logic [3:0] SYM_NUM  = 4'd5;
   localparam logic [3:0] SYM_LP   = 4'd6;
   localparam logic [3:0] SYM_RP   = 4'd7;
   localparam logic [3:0] SYM_END  = 4'd8;
   localparam logic [3:0] NT_E     = 4'd9;
   localparam logic [3:0] NT_EL    = 4'd10;
   localparam logic [3:0] NT_T     = 4'd11;
   localparam logic [3:0] NT_TL    = 4'd12;
   localparam logic [3:0] NT_F     = 4'd13;

   // Production numbers
   localparam logic [3:0] RULE_NONE     = 4'd0;
   localparam logic [3:0] RULE_E_TE     = 4'd1;
   localparam logic [3:0] RULE_EL_ADD   = 4'd2;
   localparam logic [3:0] RULE_EL_SUB   = 4'd3;
   localparam logic [3:0] RULE_EL_EMPTY = 4'd4;
   localparam logic [3:0] RULE_T_FT     = 4'd5;
   localparam logic [3:0] RULE_TL_MUL   = 4'd6;
   localparam logic [3:0] RULE_TL_DIV   = 4'd7;
   localparam logic [3:0] RULE_TL_EMPTY = 4'd8;
   localparam logic [3:0] RULE_F_NUM    = 4'd9;
   localparam logic [3:0] RULE_F_PAR    = 4'd10;

   // Per-character result codes
   typedef enum logic [2:0] {
      ST_RUN      = 3'd0,
      ST_ACCEPT   = 3'd1,
      ST_LEXERR   = 3'd2,
      ST_SYNERR   = 3'd3,
      ST_OVERFLOW = 3'd4,
      ST_IGNORED  = 3'd5
   } status_type;

   // Outcome of one lexer look at the current character
   typedef enum logic [1:0] {
      LX_DONE = 2'd0,
      LX_ERR  = 2'd1,
      LX_NUM  = 2'd2,
      LX_OP   = 2'd3
   } lex_kind_type;

   // Controller to datapath
   typedef struct packed {
      logic       accept;
      logic       lex_update;
      logic       lex_clear;
      logic       tok_load;
      logic       expand;
      logic       push;
      logic       pop;
      logic       pop_load;
      logic       emit;
      status_type code;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic         finished;
      lex_kind_type lex_kind;
      logic         top_terminal;
      logic         top_match;
      logic         tok_end;
      logic         rule_none;
      logic         rule_empty;
      logic         push_done;
      logic         stack_full;
      logic         out_free;
   } dp_status_type;

   // LL(1) table: production for nonterminal nt on lookahead tok
   function automatic logic [3:0] parse_rule(input logic [3:0] nt, input logic [3:0] tok);
      logic [3:0] r;
      r = RULE_NONE;
      case (nt)
         NT_E: begin
            if (tok == SYM_NUM || tok == SYM_LP) r = RULE_E_TE;
         end
         NT_EL: begin
            if (tok == SYM_ADD) r = RULE_EL_ADD;
            else if (tok == SYM_SUB) r = RULE_EL_SUB;
            else if (tok == SYM_RP || tok == SYM_END) r = RULE_EL_EMPTY;
         end
         NT_T: begin
            if (tok == SYM_NUM || tok == SYM_LP) r = RULE_T_FT;
         end
         NT_TL: begin
            if (tok == SYM_MUL) r = RULE_TL_MUL;
            else if (tok == SYM_DIV) r = RULE_TL_DIV;
            else if (tok == SYM_ADD || tok == SYM_SUB || tok == SYM_RP || tok == SYM_END)
               r = RULE_TL_EMPTY;
         end
         NT_F: begin
            if (tok == SYM_NUM) r = RULE_F_NUM;
            else if (tok == SYM_LP) r = RULE_F_PAR;
         end
         default: r = RULE_NONE;
      endcase
      return r;
   endfunction

   // Right-hand side length of a production
   function automatic logic [1:0] rule_len(input logic [3:0] rule);
      logic [1:0] n;
      case (rule)
         RULE_E_TE, RULE_T_FT:                        n = 2'd2;
         RULE_EL_ADD, RULE_EL_SUB, RULE_TL_MUL,
         RULE_TL_DIV, RULE_F_PAR:                     n = 2'd3;
         RULE_F_NUM:                                  n = 2'd1;
         default:                                     n = 2'd0;
      endcase
      return n;
   endfunction

   // Right-hand side symbol idx (0 is leftmost) of a production
   function automatic logic [3:0] rule_rhs(input logic [3:0] rule, input logic [1:0] idx);
      logic [3:0] s;
      s = SYM_NONE;
      case (rule)
         RULE_E_TE:   s = (idx == 2'd0) ? NT_T : NT_EL;
         RULE_EL_ADD: s = (idx == 2'd0) ? SYM_ADD : ((idx == 2'd1) ? NT_T : NT_EL);
         RULE_EL_SUB: s = (idx == 2'd0) ? SYM_SUB : ((idx == 2'd1) ? NT_T : NT_EL);
         RULE_T_FT:   s = (idx == 2'd0) ? NT_F : NT_TL;
         RULE_TL_MUL: s = (idx == 2'd0) ? SYM_MUL : ((idx == 2'd1) ? NT_F : NT_TL);
         RULE_TL_DIV: s = (idx == 2'd0) ? SYM_DIV : ((idx == 2'd1) ? NT_F : NT_TL);
         RULE_F_NUM:  s = SYM_NUM;
         RULE_F_PAR:  s = (idx == 2'd0) ? SYM_LP : ((idx == 2'd1) ? NT_E : SYM_RP);
         default:     s = SYM_NONE;
      endcase
      return s;
   endfunction

endpackage

@@ rtl/lep_if.sv @@
// ============================================================================
// lep_if
// Valid/ready channels of the expression parser: character in, status out.
// ============================================================================
interface lep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       new_expression;

   modport source (output valid, char_code, new_expression, input ready);
   modport sink   (input valid, char_code, new_expression, output ready);
endinterface

interface lep_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] position;

   modport source (output valid, status, position, input ready);
   modport sink   (input valid, status, position, output ready);
endinterface

@@ rtl/ll1_expression_parser.sv @@
// ============================================================================
// ll1_expression_parser
// Character-fed LL(1) table-driven parser for E/T/F arithmetic expressions.
// ============================================================================
// One status per character, in order. A character is taken only when the
// parser is idle; a skipped one goes through the start and emit states, one
// that only advances the lexer also through lex. A token adds a parse step per
// table lookup, a push per extra symbol and a wait per pop (the symbol stack
// memory has a registered read); a character that ends a number is lexed again
// and can carry two tokens. The finished status sits in an output register, so
// the next character is taken while it waits. The stack holds STACK_DEPTH - 1
// symbols and needs no clearing after reset; only the top lives in a register.
module ll1_expression_parser (
   input  logic     clock,
   input  logic     reset,
   lep_req_if.sink  req_chan,
   lep_rsp_if.source rsp_chan
);

   lep_pkg::ctrl_cmd_type  cmd;
   lep_pkg::dp_status_type stat;

   lep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lep_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_char_code      (req_chan.char_code),
      .req_new_expression (req_chan.new_expression),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_status         (rsp_chan.status),
      .rsp_position       (rsp_chan.position)
   );

endmodule

@@ rtl/lep_ram.sv @@
// ============================================================================
// lep_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module lep_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lep_dpath.sv @@
// ============================================================================
// lep_dpath
// Datapath: lexer, token and top-of-stack registers, symbol stack memory,
// grammar table lookup, position counter and result register.
// ============================================================================
module lep_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  lep_pkg::ctrl_cmd_type   cmd,
   output lep_pkg::dp_status_type  stat,
   input  logic [7:0]              req_char_code,
   input  logic                    req_new_expression,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_status,
   output logic [15:0]             rsp_position
);

   // Character codes the lexer recognizes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LP    = 8'h28;
   localparam logic [7:0] CH_RP    = 8'h29;
   localparam logic [7:0] CH_MUL   = 8'h2A;
   localparam logic [7:0] CH_ADD   = 8'h2B;
   localparam logic [7:0] CH_SUB   = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_DIV   = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [lep_pkg::POS_WIDTH-1:0] POS_MAX  = '1;
   localparam logic [lep_pkg::SP_WIDTH-1:0]  SP_LAST  = lep_pkg::SP_WIDTH'(lep_pkg::STACK_DEPTH - 1);
   localparam logic [lep_pkg::SP_WIDTH-1:0]  SP_START = lep_pkg::SP_WIDTH'(1);

   // Lexer state, one-hot
   typedef enum logic [3:0] {
      LEX_START = 4'b0001,
      LEX_INT   = 4'b0010,
      LEX_DOT   = 4'b0100,
      LEX_FRAC  = 4'b1000
   } lex_state_type;

   lex_state_type                   lex_ff, lex_in, lex_next;
   logic [7:0]                      char_ff;
   logic [3:0]                      tok_ff, tok_in;
   logic [3:0]                      top_ff, top_in;
   logic [3:0]                      rule_ff, rule_in;
   logic [1:0]                      left_ff, left_in;
   logic [lep_pkg::SP_WIDTH-1:0]    sp_ff, sp_in;
   logic [lep_pkg::POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [lep_pkg::POS_WIDTH-1:0]   item_pos_ff, item_pos_in;
   logic                            finished_ff, finished_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   lep_pkg::status_type             rsp_status_ff;
   logic [lep_pkg::POS_WIDTH-1:0]   rsp_position_ff;

   logic                            digit;
   lep_pkg::lex_kind_type           lex_kind;
   logic [3:0]                      lex_tok;
   logic [3:0]                      rule;
   logic [1:0]                      len;
   logic [3:0]                      ram_rd_data;

   // Classify the held character against the lexer state
   assign digit = (char_ff >= CH_ZERO) && (char_ff <= CH_NINE);

   always_comb begin
      lex_kind = lep_pkg::LX_ERR;
      lex_tok  = lep_pkg::SYM_END;
      lex_next = lex_ff;
      unique case (lex_ff) inside
         LEX_START: begin
            if (digit) begin
               lex_kind = lep_pkg::LX_DONE;
               lex_next = LEX_INT;
            end else begin
               case (char_ff)
                  CH_SPACE: lex_kind = lep_pkg::LX_DONE;
                  CH_DOT: begin
                     lex_kind = lep_pkg::LX_DONE;
                     lex_next = LEX_DOT;
                  end
                  CH_ADD: begin lex_kind = lep_pkg::LX_OP; lex_tok = lep_pkg::SYM_ADD; end
                  CH_SUB: begin lex_kind = lep_pkg::LX_OP; lex_tok = lep_pkg::SYM_SUB; end
                  CH_MUL: begin lex_kind = lep_pkg::LX_OP; lex_tok = lep_pkg::SYM_MUL; end
                  CH_DIV: begin lex_kind = lep_pkg::LX_OP; lex_tok = lep_pkg::SYM_DIV; end
                  CH_LP:  begin lex_kind = lep_pkg::LX_OP; lex_tok = lep_pkg::SYM_LP;  end
                  CH_RP:  begin lex_kind = lep_pkg::LX_OP; lex_tok = lep_pkg::SYM_RP;  end
                  CH_NUL: begin lex_kind = lep_pkg::LX_OP; lex_tok = lep_pkg::SYM_END; end
                  default: lex_kind = lep_pkg::LX_ERR;
               endcase
            end
         end
         LEX_DOT: begin
            if (digit) begin
               lex_kind = lep_pkg::LX_DONE;
               lex_next = LEX_FRAC;
            end
         end
         LEX_INT, LEX_FRAC: begin
            if (digit) begin
               lex_kind = lep_pkg::LX_DONE;
            end else if (char_ff == CH_DOT && lex_ff == LEX_INT) begin
               lex_kind = lep_pkg::LX_DONE;
               lex_next = LEX_FRAC;
            end else begin
               // number ends here; the character is looked at again afterwards
               lex_kind = lep_pkg::LX_NUM;
               lex_tok  = lep_pkg::SYM_NUM;
            end
         end
         default: lex_kind = lep_pkg::LX_ERR;
      endcase
   end

   // Table lookup for the top of stack against the current token
   assign rule = lep_pkg::parse_rule(top_ff, tok_ff);
   assign len  = lep_pkg::rule_len(rule);

   always_comb begin
      stat.finished     = finished_ff;
      stat.lex_kind     = lex_kind;
      stat.top_terminal = top_ff < lep_pkg::NT_E;
      stat.top_match    = top_ff == tok_ff;
      stat.tok_end      = tok_ff == lep_pkg::SYM_END;
      stat.rule_none    = rule == lep_pkg::RULE_NONE;
      stat.rule_empty   = len == 2'd0;
      stat.push_done    = left_ff == 2'd0;
      stat.stack_full   = sp_ff == SP_LAST;
      stat.out_free     = !rsp_valid_ff || rsp_ready;
   end

   // Next-state logic for stack, lexer, position and result
   always_comb begin
      lex_in       = lex_ff;
      tok_in       = tok_ff;
      top_in       = top_ff;
      rule_in      = rule_ff;
      left_in      = left_ff;
      sp_in        = sp_ff;
      pos_in       = pos_ff;
      item_pos_in  = item_pos_ff;
      finished_in  = finished_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.accept) begin
         if (req_new_expression) begin
            lex_in      = LEX_START;
            top_in      = lep_pkg::NT_E;
            sp_in       = SP_START;
            finished_in = 1'b0;
            item_pos_in = '0;
            pos_in      = lep_pkg::POS_WIDTH'(1);
         end else begin
            item_pos_in = pos_ff;
            pos_in      = (pos_ff == POS_MAX) ? pos_ff : pos_ff + lep_pkg::POS_WIDTH'(1);
         end
      end
      if (cmd.lex_update) lex_in = lex_next;
      if (cmd.lex_clear)  lex_in = LEX_START;
      if (cmd.tok_load)   tok_in = lex_tok;
      // replace the nonterminal with the last symbol of its production
      if (cmd.expand) begin
         top_in  = lep_pkg::rule_rhs(rule, len - 2'd1);
         rule_in = rule;
         left_in = len - 2'd1;
      end
      // spill the top into memory and bring in the next symbol to the left
      if (cmd.push) begin
         top_in  = lep_pkg::rule_rhs(rule_ff, left_ff - 2'd1);
         sp_in   = sp_ff + lep_pkg::SP_WIDTH'(1);
         left_in = left_ff - 2'd1;
      end
      if (cmd.pop) sp_in = sp_ff - lep_pkg::SP_WIDTH'(1);
      if (cmd.pop_load) top_in = (sp_ff == '0) ? lep_pkg::SYM_END : ram_rd_data;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         finished_in  = finished_ff || (cmd.code != lep_pkg::ST_RUN);
      end
   end

   // Control and stack state
   always_ff @(posedge clock) begin
      if (reset) begin
         lex_ff       <= LEX_START;
         top_ff       <= lep_pkg::NT_E;
         sp_ff        <= SP_START;
         pos_ff       <= '0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_ff      <= 2'd0;
      end else begin
         lex_ff       <= lex_in;
         top_ff       <= top_in;
         sp_ff        <= sp_in;
         pos_ff       <= pos_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= left_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      tok_ff      <= tok_in;
      rule_ff     <= rule_in;
      item_pos_ff <= item_pos_in;
      if (cmd.accept) char_ff <= req_char_code;
      if (cmd.emit) begin
         rsp_status_ff   <= cmd.code;
         rsp_position_ff <= item_pos_ff;
      end
   end

   // Symbol stack below the top entry; entry 0 is the end marker and never stored
   lep_ram #(
      .WIDTH (4),
      .DEPTH (lep_pkg::STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (sp_ff),
      .wr_data (top_ff),
      .rd_en   (cmd.pop),
      .rd_addr (sp_ff - lep_pkg::SP_WIDTH'(1)),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_position_ff;

endmodule

@@ rtl/lep_ctrl.sv @@
// ============================================================================
// lep_ctrl
// Controller: steps each character through lexing, table expansion, pushes,
// pops and result hand-off.
// ============================================================================
module lep_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lep_pkg::dp_status_type stat,
   output lep_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [7:0] {
      S_IDLE       = 8'b0000_0001,
      S_START      = 8'b0000_0010,
      S_LEX        = 8'b0000_0100,
      S_PARSE      = 8'b0000_1000,
      S_PUSH       = 8'b0001_0000,
      S_MATCH_WAIT = 8'b0010_0000,
      S_EMPTY_WAIT = 8'b0100_0000,
      S_EMIT       = 8'b1000_0000
   } state_type;

   state_type           state_ff, state_in;
   lep_pkg::status_type code_ff, code_in;
   logic                num_ff, num_in;

   assign req_ready = state_ff == S_IDLE;

   // Sequence one character
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      num_in   = num_ff;
      cmd      = '0;
      cmd.code = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_START;
            end
         end
         S_START: begin
            if (stat.finished) begin
               code_in  = lep_pkg::ST_IGNORED;
               state_in = S_EMIT;
            end else begin
               state_in = S_LEX;
            end
         end
         S_LEX: begin
            case (stat.lex_kind)
               lep_pkg::LX_DONE: begin
                  cmd.lex_update = 1'b1;
                  code_in        = lep_pkg::ST_RUN;
                  state_in       = S_EMIT;
               end
               lep_pkg::LX_NUM: begin
                  cmd.tok_load = 1'b1;
                  num_in       = 1'b1;
                  state_in     = S_PARSE;
               end
               lep_pkg::LX_OP: begin
                  cmd.tok_load = 1'b1;
                  num_in       = 1'b0;
                  state_in     = S_PARSE;
               end
               default: begin
                  code_in  = lep_pkg::ST_LEXERR;
                  state_in = S_EMIT;
               end
            endcase
         end
         S_PARSE: begin
            if (stat.top_terminal) begin
               if (!stat.top_match) begin
                  code_in  = lep_pkg::ST_SYNERR;
                  state_in = S_EMIT;
               end else if (stat.tok_end) begin
                  code_in  = lep_pkg::ST_ACCEPT;
                  state_in = S_EMIT;
               end else begin
                  cmd.pop  = 1'b1;
                  state_in = S_MATCH_WAIT;
               end
            end else if (stat.rule_none) begin
               code_in  = lep_pkg::ST_SYNERR;
               state_in = S_EMIT;
            end else if (stat.rule_empty) begin
               cmd.pop  = 1'b1;
               state_in = S_EMPTY_WAIT;
            end else begin
               cmd.expand = 1'b1;
               state_in   = S_PUSH;
            end
         end
         S_PUSH: begin
            if (stat.push_done) begin
               state_in = S_PARSE;
            end else if (stat.stack_full) begin
               code_in  = lep_pkg::ST_OVERFLOW;
               state_in = S_EMIT;
            end else begin
               cmd.push = 1'b1;
            end
         end
         S_MATCH_WAIT: begin
            cmd.pop_load = 1'b1;
            if (num_ff) begin
               // number matched: look at the terminating character again
               cmd.lex_clear = 1'b1;
               state_in      = S_LEX;
            end else begin
               code_in  = lep_pkg::ST_RUN;
               state_in = S_EMIT;
            end
         end
         S_EMPTY_WAIT: begin
            cmd.pop_load = 1'b1;
            state_in     = S_PARSE;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         num_ff   <= 1'b0;
         code_ff  <= lep_pkg::ST_RUN;
      end else begin
         state_ff <= state_in;
         num_ff   <= num_in;
         code_ff  <= code_in;
      end
   end

endmodule

@@ rtl/lep_checker.sv @@
// ============================================================================
// lep_checker
// Port-level checks of the expression parser, bound to the top level.
// ============================================================================
module lep_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_position
);

   // Status codes stay within the defined set
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= lep_pkg::ST_IGNORED))
      else $error("status code out of range");

   // The first character of an expression is never ignored
   a_first_not_ignored: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == lep_pkg::ST_IGNORED) |-> (rsp_position != 16'd0))
      else $error("ignored status at position zero");

   // One character at a time: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while a character is in progress");

   // A stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_position)))
      else $error("stalled result changed");

endmodule

bind ll1_expression_parser lep_checker u_lep_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_status   (rsp_chan.status),
   .rsp_position (rsp_chan.position)
);
